// ----- rtl/ckcu_pkg.sv -----
// Shared types and constants for the colour key compositor and upscaler.
package ckcu_pkg;

  // Field widths
  localparam int COLOUR_W  = 24;
  localparam int RGB565_W  = 16;
  localparam int POS_W     = 8;
  localparam int SCALE_W   = 4;
  localparam int VIEW_W    = 10;
  localparam int STRIDE_W  = 10;
  localparam int OUT_ADDR_W = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Physical coordinates: 1023 + 255 * 8 + 7 fits in 12 bits
  localparam int COORD_W   = 12;
  // Step counter within a block, scale never exceeds 8
  localparam int STEP_W    = 3;
  // Row start product plus column offset
  localparam int PROD_W    = COORD_W + STRIDE_W + 1;

  // Queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  // Truncation masks for RGB888 to RGB565
  localparam logic [7:0] MASK5 = 8'hF8;
  localparam logic [7:0] MASK6 = 8'hFC;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_COLOUR  = 3'd0,
    CFG_SCALE       = 3'd1,
    CFG_OFFSET_COL  = 3'd2,
    CFG_OFFSET_ROW  = 3'd3,
    CFG_IMAGE_COLS  = 3'd4,
    CFG_IMAGE_ROWS  = 3'd5,
    CFG_LINE_STRIDE = 3'd6
  } cfg_index_t;

  // Configuration as seen by front and back, scale already clamped
  typedef struct packed {
    logic [COLOUR_W-1:0] key_colour;
    logic [SCALE_W-1:0]  eff_scale;
    logic [VIEW_W-1:0]   offset_col;
    logic [VIEW_W-1:0]   offset_row;
    logic [POS_W-1:0]    image_cols;
    logic [POS_W-1:0]    image_rows;
    logic [STRIDE_W-1:0] line_stride;
  } cfg_t;

  // One classified pixel waiting for the back end
  typedef struct packed {
    logic [COORD_W-1:0]  col0;
    logic [COORD_W-1:0]  row0;
    logic [RGB565_W-1:0] colour;
  } entry_t;

  // RGB888 to RGB565 by truncation
  function automatic logic [RGB565_W-1:0] pack565(input logic [COLOUR_W-1:0] rgb);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = rgb[23:16] & MASK5;
    g = rgb[15:8] & MASK6;
    b = rgb[7:0];
    pack565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ----- rtl/ckcu_front.sv -----
// Front end: range check, colour key select, RGB565 pack and block origin.
module ckcu_front import ckcu_pkg::*; (
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [POS_W-1:0]    in_pixel_x,
  input  logic [POS_W-1:0]    in_pixel_y,
  input  logic [COLOUR_W-1:0] in_fg_colour,
  input  logic [COLOUR_W-1:0] in_bg_colour,
  input  logic                q_full,
  output logic                q_push,
  output entry_t              q_entry
);

  logic               in_range;
  logic [POS_W-1:0]   y_mirror;
  logic [COORD_W-1:0] col_off;
  logic [COORD_W-1:0] row_off;

  // Accept whenever the queue has room; dropped words just vanish
  assign in_ready = !q_full;
  assign in_range = (in_pixel_x < cfg.image_cols) && (in_pixel_y < cfg.image_rows);
  assign q_push   = in_valid && in_ready && in_range;

  // Rotation: x gives the row, mirrored y gives the column
  always_comb begin
    y_mirror       = cfg.image_rows - 8'd1 - in_pixel_y;
    col_off        = COORD_W'(y_mirror) * COORD_W'(cfg.eff_scale);
    row_off        = COORD_W'(in_pixel_x) * COORD_W'(cfg.eff_scale);
    q_entry.col0   = COORD_W'(cfg.offset_col) + col_off;
    q_entry.row0   = COORD_W'(cfg.offset_row) + row_off;
    q_entry.colour = pack565((in_fg_colour == cfg.key_colour) ? in_bg_colour : in_fg_colour);
  end

endmodule

// ----- rtl/ckcu_fifo.sv -----
// Short queue of classified pixels between front and back.
module ckcu_fifo import ckcu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  entry_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count above depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue pushed while full");
`endif

endmodule

// ----- rtl/ckcu_back.sv -----
// Back end: walks the scale-by-scale block and drives the write channel.
module ckcu_back import ckcu_pkg::*; #(
  parameter int ADDRESS_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  q_not_empty,
  input  entry_t                q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_ADDR_W-1:0] out_write_address,
  output logic [RGB565_W-1:0]   out_write_colour,
  output logic                  out_last_write
);

  logic                    busy_r, busy_nxt;
  logic [STEP_W-1:0]       px_r, px_nxt;
  logic [STEP_W-1:0]       py_r, py_nxt;
  logic [RGB565_W-1:0]     colour_r, colour_nxt;
  logic [ADDRESS_BITS-1:0] rowstart_r, rowstart_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;

  logic [STEP_W-1:0]       s_m1;
  logic                    row_end;
  logic                    last;
  logic                    fire;
  logic                    load;
  logic [PROD_W-1:0]       origin;
  logic [ADDRESS_BITS-1:0] stride_ext;

  assign s_m1       = STEP_W'(cfg.eff_scale - 4'd1);
  assign row_end    = (px_r == s_m1);
  assign last       = row_end && (py_r == s_m1);
  assign fire       = busy_r && out_ready;
  assign load       = q_not_empty && (!busy_r || (out_ready && last));
  assign q_pop      = load;
  assign stride_ext = ADDRESS_BITS'(cfg.line_stride);
  // First address of the block
  assign origin     = PROD_W'(q_head.row0) * PROD_W'(cfg.line_stride)
                    + PROD_W'(q_head.col0);

  // Block walk, row by row
  always_comb begin
    busy_nxt     = busy_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    colour_nxt   = colour_r;
    rowstart_nxt = rowstart_r;
    addr_nxt     = addr_r;
    if (load) begin
      busy_nxt     = 1'b1;
      px_nxt       = '0;
      py_nxt       = '0;
      colour_nxt   = q_head.colour;
      rowstart_nxt = ADDRESS_BITS'(origin);
      addr_nxt     = ADDRESS_BITS'(origin);
    end else if (fire) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else if (row_end) begin
        px_nxt       = '0;
        py_nxt       = py_r + 1'b1;
        rowstart_nxt = rowstart_r + stride_ext;
        addr_nxt     = rowstart_r + stride_ext;
      end else begin
        px_nxt   = px_r + 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      px_r   <= '0;
      py_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
    end
  end

  always_ff @(posedge clk) begin
    colour_r   <= colour_nxt;
    rowstart_r <= rowstart_nxt;
    addr_r     <= addr_nxt;
  end

  // Output word straight from the walk registers
  assign out_valid         = busy_r;
  assign out_write_address = OUT_ADDR_W'(addr_r);
  assign out_write_colour  = colour_r;
  assign out_last_write    = last;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (px_r <= s_m1 && py_r <= s_m1))
    else $error("block step counter beyond scale");
  a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && px_r == '0) |-> (addr_r == rowstart_r))
    else $error("row start address mismatch");
  a_load_origin: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && px_r == '0 && py_r == '0))
    else $error("block did not start at origin");
`endif

endmodule

// ----- rtl/colour_key_compositor_upscaler.sv -----
// Top level: configuration registers, front end, queue and block walker.
// With the walker idle, an accepted pixel word is first written into the queue and then
// loaded into the walker registers, which offer its first write on the result channel.
// The walker gives one write per cycle while out_ready is high, scale*scale writes per
// pixel (16 at scale 4); an out-of-range pixel is accepted and dropped without queueing.
// Reset (synchronous, active low) loads register defaults and empties queue and walker.
module colour_key_compositor_upscaler import ckcu_pkg::*; #(
  parameter int ADDRESS_BITS = 20,
  parameter int MAX_SCALE    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_W-1:0]      in_pixel_x,
  input  logic [POS_W-1:0]      in_pixel_y,
  input  logic [COLOUR_W-1:0]   in_fg_colour,
  input  logic [COLOUR_W-1:0]   in_bg_colour,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_ADDR_W-1:0] out_write_address,
  output logic [RGB565_W-1:0]   out_write_colour,
  output logic                  out_last_write
);

  logic [COLOUR_W-1:0] key_colour_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [VIEW_W-1:0]   offset_col_r;
  logic [VIEW_W-1:0]   offset_row_r;
  logic [POS_W-1:0]    image_cols_r;
  logic [POS_W-1:0]    image_rows_r;
  logic [STRIDE_W-1:0] line_stride_r;

  cfg_t   cfg;
  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   q_not_empty;
  entry_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_colour_r  <= '0;
      scale_r       <= 4'd4;
      offset_col_r  <= '0;
      offset_row_r  <= '0;
      image_cols_r  <= 8'd112;
      image_rows_r  <= 8'd92;
      line_stride_r <= 10'd368;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_KEY_COLOUR:  key_colour_r  <= cfg_data[COLOUR_W-1:0];
        CFG_SCALE:       scale_r       <= cfg_data[SCALE_W-1:0];
        CFG_OFFSET_COL:  offset_col_r  <= cfg_data[VIEW_W-1:0];
        CFG_OFFSET_ROW:  offset_row_r  <= cfg_data[VIEW_W-1:0];
        CFG_IMAGE_COLS:  image_cols_r  <= cfg_data[POS_W-1:0];
        CFG_IMAGE_ROWS:  image_rows_r  <= cfg_data[POS_W-1:0];
        CFG_LINE_STRIDE: line_stride_r <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp scale into 1..MAX_SCALE and bundle the settings
  always_comb begin
    cfg.key_colour  = key_colour_r;
    cfg.offset_col  = offset_col_r;
    cfg.offset_row  = offset_row_r;
    cfg.image_cols  = image_cols_r;
    cfg.image_rows  = image_rows_r;
    cfg.line_stride = line_stride_r;
    if (scale_r == '0) begin
      cfg.eff_scale = 4'd1;
    end else if (scale_r > SCALE_W'(MAX_SCALE)) begin
      cfg.eff_scale = SCALE_W'(MAX_SCALE);
    end else begin
      cfg.eff_scale = scale_r;
    end
  end

  ckcu_front u_front (
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_fg_colour (in_fg_colour),
    .in_bg_colour (in_bg_colour),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  ckcu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  ckcu_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_not_empty       (q_not_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_colour  (out_write_colour),
    .out_last_write    (out_last_write)
  );

endmodule
